/* sv/ils_pkg.sv */
`timescale 1ns / 1ps

package ils_pkg;

   localparam int CHAR_BITS  = 8;
   localparam int VALUE_BITS = 32;
   localparam int WORD_BITS  = 32;
   localparam int WIDE_BITS  = WORD_BITS + 4;
   localparam int PHASE_BITS = 3;

   localparam logic [WORD_BITS-1:0] WORD_MASK  = {WORD_BITS{1'b1}};
   localparam logic [WORD_BITS-1:0] SIGNED_MAX = WORD_MASK >> 1;

   // scan phases
   localparam logic [PHASE_BITS-1:0] PH_IDLE   = 3'd0;
   localparam logic [PHASE_BITS-1:0] PH_ZERO   = 3'd1;
   localparam logic [PHASE_BITS-1:0] PH_OCT    = 3'd2;
   localparam logic [PHASE_BITS-1:0] PH_DEC    = 3'd3;
   localparam logic [PHASE_BITS-1:0] PH_HEX    = 3'd4;
   localparam logic [PHASE_BITS-1:0] PH_SUFFIX = 3'd5;
   localparam logic [PHASE_BITS-1:0] PH_TAIL   = 3'd6;
   localparam logic [PHASE_BITS-1:0] PH_FLOAT  = 3'd7;

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic                  is_unsigned;
      logic                  is_float;
      logic                  overflowed;
      logic                  bad_octal_digit;
      logic                  empty_hex;
      logic                  bad_pp_number;
   } rsp_type;

   function automatic logic is_digit(input logic [CHAR_BITS-1:0] c);
      return c inside {["0":"9"]};
   endfunction

   function automatic logic is_pp_char(input logic [CHAR_BITS-1:0] c);
      return c inside {["0":"9"], ["a":"z"], ["A":"Z"], "_", "."};
   endfunction

   function automatic logic is_e(input logic [CHAR_BITS-1:0] c);
      return c inside {"e", "E"};
   endfunction

   function automatic logic is_sign(input logic [CHAR_BITS-1:0] c);
      return c inside {"+", "-"};
   endfunction

   function automatic logic is_hex(input logic [CHAR_BITS-1:0] c);
      return c inside {["0":"9"], ["a":"f"], ["A":"F"]};
   endfunction

   // digit weight; letters a..f / A..F have low nibble 1..6
   function automatic logic [3:0] hex_weight(input logic [CHAR_BITS-1:0] c);
      logic [3:0] w;
      if (is_digit(c)) begin
         w = c[3:0];
      end else begin
         w = c[3:0] + 4'd9;
      end
      return w;
   endfunction

endpackage

/* sv/ils_if.sv */
`timescale 1ns / 1ps

interface ils_req_if;
   import ils_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CHAR_BITS-1:0] ch;

   modport source (output valid, output ch, input ready);
   modport sink   (input valid, input ch, output ready);
endinterface

interface ils_rsp_if;
   import ils_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] value;
   logic                  is_unsigned;
   logic                  is_float;
   logic                  overflowed;
   logic                  bad_octal_digit;
   logic                  empty_hex;
   logic                  bad_pp_number;

   modport source (output valid, output value, output is_unsigned, output is_float,
                   output overflowed, output bad_octal_digit, output empty_hex,
                   output bad_pp_number, input ready);
   modport sink   (input valid, input value, input is_unsigned, input is_float,
                   input overflowed, input bad_octal_digit, input empty_hex,
                   input bad_pp_number, output ready);
endinterface

/* sv/integer_literal_scanner.sv */
`timescale 1ns / 1ps

// channel  | dir | payload                                        | beat
// ---------+-----+------------------------------------------------+------------------
// req_if   | in  | ch (8)                                         | valid && ready
// rsp_if   | out | value (32), is_unsigned, is_float, overflowed, | valid && ready
//          |     | bad_octal_digit, empty_hex, bad_pp_number      |
//
// one character per cycle unless a stalled rsp holds it off: a beat lands in the input
// register, then the scan step (shift-add, overflow compare, suffix/tail decode) runs
// and loads the result register when it closes a constant.
// reset (synchronous) returns the scanner to idle with all flags cleared.
// a stalled rsp only holds the input stage; req_ready drops once both are full.

module integer_literal_scanner (
   input logic   clock,
   input logic   reset,
   ils_req_if.sink   req_if,
   ils_rsp_if.source rsp_if
);
   import ils_pkg::*;

   // input stage
   logic                 in_valid_ff;
   logic [CHAR_BITS-1:0] in_ch_ff;
   logic                 step_go;

   // scan state
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [WORD_BITS-1:0]  accum_ff, accum_in;
   logic                  ovf_ff, ovf_in;
   logic                  oct_err_ff, oct_err_in;
   logic                  hex_seen_ff, hex_seen_in;
   logic                  u_seen_ff, u_seen_in;
   logic                  l_seen_ff, l_seen_in;
   logic                  tail_ff, tail_in;
   logic                  last_e_ff, last_e_in;

   // result register
   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;
   logic    emit;

   // the scan step may run when the result register is empty or draining
   assign step_go      = in_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || step_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
      if (req_if.ready && req_if.valid) begin
         in_ch_ff <= req_if.ch;
      end
   end

   // one scan step, following the fall-through order of the phases
   always_comb begin : scan_step
      logic [PHASE_BITS-1:0] p;
      logic                  done;
      logic [CHAR_BITS-1:0]  c;
      logic [WIDE_BITS-1:0]  dec_wide;
      logic [WORD_BITS-1:0]  v;

      c           = in_ch_ff;
      p           = phase_ff;
      done        = 1'b0;
      phase_in    = phase_ff;
      accum_in    = accum_ff;
      ovf_in      = ovf_ff;
      oct_err_in  = oct_err_ff;
      hex_seen_in = hex_seen_ff;
      u_seen_in   = u_seen_ff;
      l_seen_in   = l_seen_ff;
      tail_in     = tail_ff;
      last_e_in   = last_e_ff;
      emit        = 1'b0;
      rsp_in      = '0;
      dec_wide    = ({4'd0, accum_ff} << 3) + ({4'd0, accum_ff} << 1)
                    + WIDE_BITS'(c[3:0]);
      v           = ovf_ff ? SIGNED_MAX : accum_ff;

      case (phase_ff)
         PH_IDLE: begin
            if (is_digit(c)) begin
               accum_in    = WORD_BITS'(c[3:0]);
               hex_seen_in = 1'b1;
               phase_in    = (c == "0") ? PH_ZERO : PH_DEC;
            end
         end
         PH_FLOAT: begin
            if (is_pp_char(c)) begin
               last_e_in = is_e(c);
            end else if (is_sign(c) && last_e_ff) begin
               last_e_in = 1'b0;
            end else begin
               phase_in   = PH_IDLE;
               accum_in   = '0;
               ovf_in     = 1'b0;
               oct_err_in = 1'b0;
               hex_seen_in = 1'b0;
               u_seen_in  = 1'b0;
               l_seen_in  = 1'b0;
               tail_in    = 1'b0;
               last_e_in  = 1'b0;
            end
         end
         default: begin
            if (p == PH_ZERO) begin
               if (c inside {"x", "X"}) begin
                  hex_seen_in = 1'b0;
                  p           = PH_HEX;
                  done        = 1'b1;
               end else begin
                  p = PH_OCT;
               end
            end
            if (!done && (p == PH_OCT || p == PH_DEC)) begin
               if (is_digit(c)) begin
                  done = 1'b1;
                  if (p == PH_OCT) begin
                     if (c inside {"8", "9"}) begin
                        oct_err_in = 1'b1;
                     end
                     if (accum_ff[WORD_BITS-1 -: 3] != 3'd0) begin
                        ovf_in = 1'b1;
                     end else if (!ovf_ff) begin
                        accum_in = (accum_ff << 3) + WORD_BITS'(c[3:0]);
                     end
                  end else begin
                     if (dec_wide[WIDE_BITS-1 -: 4] != 4'd0) begin
                        ovf_in = 1'b1;
                     end else if (!ovf_ff) begin
                        accum_in = dec_wide[WORD_BITS-1:0];
                     end
                  end
               end else if (c == "." || is_e(c)) begin
                  // float handoff: everything cleared, float result out
                  done               = 1'b1;
                  emit               = 1'b1;
                  rsp_in.is_float    = 1'b1;
                  p                  = PH_FLOAT;
                  accum_in           = '0;
                  ovf_in             = 1'b0;
                  oct_err_in         = 1'b0;
                  hex_seen_in        = 1'b0;
                  u_seen_in          = 1'b0;
                  l_seen_in          = 1'b0;
                  tail_in            = 1'b0;
                  last_e_in          = is_e(c);
               end else begin
                  p = PH_SUFFIX;
               end
            end else if (!done && p == PH_HEX) begin
               if (is_hex(c)) begin
                  done        = 1'b1;
                  hex_seen_in = 1'b1;
                  if (accum_ff[WORD_BITS-1 -: 4] != 4'd0) begin
                     ovf_in = 1'b1;
                  end else if (!ovf_ff) begin
                     accum_in = (accum_ff << 4) + WORD_BITS'(hex_weight(c));
                  end
                  last_e_in = is_e(c);
               end else begin
                  p = PH_SUFFIX;
               end
            end
            if (!done && p == PH_SUFFIX) begin
               if (c inside {"u", "U"} && !u_seen_ff) begin
                  done      = 1'b1;
                  u_seen_in = 1'b1;
                  last_e_in = 1'b0;
               end else if (c inside {"l", "L"} && !l_seen_ff) begin
                  done      = 1'b1;
                  l_seen_in = 1'b1;
                  last_e_in = 1'b0;
               end else begin
                  p = PH_TAIL;
               end
            end
            if (!done) begin
               // tail: extra pp-number characters, or the terminator
               if (is_pp_char(c)) begin
                  tail_in   = 1'b1;
                  last_e_in = is_e(c);
               end else if (is_sign(c) && last_e_ff) begin
                  tail_in   = 1'b1;
                  last_e_in = 1'b0;
               end else begin
                  emit                   = 1'b1;
                  rsp_in.value           = VALUE_BITS'(v);
                  rsp_in.is_unsigned     = u_seen_ff || v[WORD_BITS-1];
                  rsp_in.overflowed      = ovf_ff;
                  rsp_in.bad_octal_digit = oct_err_ff;
                  rsp_in.empty_hex       = !hex_seen_ff;
                  rsp_in.bad_pp_number   = tail_ff;
                  p                      = PH_IDLE;
                  accum_in               = '0;
                  ovf_in                 = 1'b0;
                  oct_err_in             = 1'b0;
                  hex_seen_in            = 1'b0;
                  u_seen_in              = 1'b0;
                  l_seen_in              = 1'b0;
                  tail_in                = 1'b0;
                  last_e_in              = 1'b0;
               end
            end
            phase_in = p;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         accum_ff    <= '0;
         ovf_ff      <= 1'b0;
         oct_err_ff  <= 1'b0;
         hex_seen_ff <= 1'b0;
         u_seen_ff   <= 1'b0;
         l_seen_ff   <= 1'b0;
         tail_ff     <= 1'b0;
         last_e_ff   <= 1'b0;
      end else if (step_go) begin
         phase_ff    <= phase_in;
         accum_ff    <= accum_in;
         ovf_ff      <= ovf_in;
         oct_err_ff  <= oct_err_in;
         hex_seen_ff <= hex_seen_in;
         u_seen_ff   <= u_seen_in;
         l_seen_ff   <= l_seen_in;
         tail_ff     <= tail_in;
         last_e_ff   <= last_e_in;
      end
   end

   // result register: loads on an emitting step, clears when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step_go) begin
         rsp_valid_ff <= emit;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (step_go && emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.value           = rsp_ff.value;
   assign rsp_if.is_unsigned     = rsp_ff.is_unsigned;
   assign rsp_if.is_float        = rsp_ff.is_float;
   assign rsp_if.overflowed      = rsp_ff.overflowed;
   assign rsp_if.bad_octal_digit = rsp_ff.bad_octal_digit;
   assign rsp_if.empty_hex       = rsp_ff.empty_hex;
   assign rsp_if.bad_pp_number   = rsp_ff.bad_pp_number;

   // a float handoff carries nothing but its flag
   a_float_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.is_float |->
         rsp_ff.value == '0 && !rsp_ff.is_unsigned && !rsp_ff.overflowed &&
         !rsp_ff.bad_octal_digit && !rsp_ff.empty_hex && !rsp_ff.bad_pp_number)
      else $error("float result carries integer fields");

   // overflow always reports the saturated value
   a_ovf_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.overflowed |-> rsp_ff.value == VALUE_BITS'(SIGNED_MAX))
      else $error("overflowed result not saturated");

   // an empty hex constant never accumulated anything
   a_empty_hex: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.empty_hex |-> rsp_ff.value == '0 && !rsp_ff.overflowed)
      else $error("empty hex constant with nonzero value");

   // a full input stage behind a stalled result must hold off new beats
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && rsp_valid_ff && !rsp_if.ready |-> !req_if.ready)
      else $error("input accepted while pipeline blocked");

   // idle phase means no scan flags are pending
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> !ovf_ff && !oct_err_ff && !u_seen_ff && !l_seen_ff && !tail_ff)
      else $error("idle with stale scan flags");

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

// integer_literal_scanner check: characters go in one beat at a time, every constant
// (predicted, or pinned from the directed table) is queued and matched field by field against rsp beats

module testbench;
   import ils_pkg::*;

   localparam int RANDOM_CHARS     = 1700;
   localparam int LONG_HOLD_CYCLES = 150;
   localparam int DRAIN_CYCLES     = 20;
   localparam int TIMEOUT_NS       = 5_000_000;

   localparam logic [CHAR_BITS-1:0] END_OF_INPUT = 8'h00;

   // scanner state as the predictor tracks it
   typedef struct packed {
      logic [PHASE_BITS-1:0] phase;
      logic [WORD_BITS-1:0]  accum;
      logic                  overflow;
      logic                  octal_err;
      logic                  hex_digit;
      logic                  u_sfx;
      logic                  l_sfx;
      logic                  tail;
      logic                  last_e;
   } lex_state_type;

   // one directed row: body text, then the terminating character
   typedef struct {
      string                body;
      logic [CHAR_BITS-1:0] term;
      int                   pinned;
      rsp_type              want;
   } lex_row_type;

   logic clock;
   logic reset;

   ils_req_if req_if ();
   ils_rsp_if rsp_if ();

   integer_literal_scanner DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   lex_state_type lex;
   rsp_type       pending_constants[$];
   int            fail_count    = 0;
   int            scanned_chars = 0;
   int            hold_requests = 0;
   bit            quiet         = 1'b0;

   // pinned expectation handed over from the directed table
   rsp_type row_want;
   int      pinned_count = 0;
   int      pinned_taken = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // generous run limit, well above the slowest legal run
   initial begin
      #(TIMEOUT_NS);
      $display("testbench: FAIL");
      $finish;
   end

   // ------------------------------------------------------------------
   // character classes
   // ------------------------------------------------------------------
   function automatic bit digit_char(input logic [CHAR_BITS-1:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit pp_char(input logic [CHAR_BITS-1:0] c);
      return digit_char(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z")
             || c == "_" || c == ".";
   endfunction

   function automatic bit e_char(input logic [CHAR_BITS-1:0] c);
      return c == "e" || c == "E";
   endfunction

   function automatic bit sign_char(input logic [CHAR_BITS-1:0] c);
      return c == "+" || c == "-";
   endfunction

   function automatic rsp_type const_result(input logic [VALUE_BITS-1:0] value,
                                            input int uns, input int flt, input int ovf,
                                            input int oct, input int ehex, input int pp);
      rsp_type r;
      r.value           = value;
      r.is_unsigned     = (uns != 0);
      r.is_float        = (flt != 0);
      r.overflowed      = (ovf != 0);
      r.bad_octal_digit = (oct != 0);
      r.empty_hex       = (ehex != 0);
      r.bad_pp_number   = (pp != 0);
      return r;
   endfunction

   // ------------------------------------------------------------------
   // predictor: one character in, at most one constant out
   // ------------------------------------------------------------------
   function automatic void lex_clear();
      lex       = '0;
      lex.phase = PH_IDLE;
   endfunction

   function automatic bit lex_char(input logic [CHAR_BITS-1:0] c, output rsp_type tok);
      logic [PHASE_BITS-1:0] ph;
      logic [3:0]            d;
      bit                    hexd;
      logic [WORD_BITS-1:0]  v;
      tok  = '0;
      ph   = lex.phase;
      hexd = 1'b0;
      d    = '0;

      // idle: only a digit opens a constant, everything else falls away
      if (ph == PH_IDLE) begin
         if (digit_char(c)) begin
            lex.accum     = WORD_BITS'(c - "0");
            lex.hex_digit = 1'b1;
            lex.phase     = (c == "0") ? PH_ZERO : PH_DEC;
         end
         return 1'b0;
      end

      // float handoff: swallow the pp-number, then back to idle silently
      if (ph == PH_FLOAT) begin
         if (pp_char(c)) begin
            lex.last_e = e_char(c);
         end else if (sign_char(c) && lex.last_e) begin
            lex.last_e = 1'b0;
         end else begin
            lex_clear();
         end
         return 1'b0;
      end

      // leading zero: x/X makes it hex, anything else is octal
      if (ph == PH_ZERO) begin
         if (c == "x" || c == "X") begin
            lex.phase     = PH_HEX;
            lex.hex_digit = 1'b0;
            return 1'b0;
         end
         ph = PH_OCT;
      end

      if (ph == PH_OCT || ph == PH_DEC) begin
         if (digit_char(c)) begin
            d = 4'(c - "0");
            if (ph == PH_OCT) begin
               // 8 and 9 flagged but still weighted, wrapping in the word
               if (c == "8" || c == "9") lex.octal_err = 1'b1;
               if (lex.accum[WORD_BITS-1 -: 3] != '0) begin
                  lex.overflow = 1'b1;
               end else if (!lex.overflow) begin
                  lex.accum = (lex.accum << 3) + WORD_BITS'(d);
               end
            end else begin
               if (lex.accum > (WORD_MASK - WORD_BITS'(d)) / 32'd10) begin
                  lex.overflow = 1'b1;
               end else if (!lex.overflow) begin
                  lex.accum = lex.accum * 32'd10 + WORD_BITS'(d);
               end
            end
            lex.phase = ph;
            return 1'b0;
         end
         // '.', e or E: float result with every other field clear
         if (c == "." || e_char(c)) begin
            lex_clear();
            lex.phase    = PH_FLOAT;
            lex.last_e   = e_char(c);
            tok.is_float = 1'b1;
            return 1'b1;
         end
         ph = PH_SUFFIX;
      end else if (ph == PH_HEX) begin
         if (digit_char(c)) begin
            d    = 4'(c - "0");
            hexd = 1'b1;
         end else if (c >= "a" && c <= "f") begin
            d    = 4'(c - "a" + 8'd10);
            hexd = 1'b1;
         end else if (c >= "A" && c <= "F") begin
            d    = 4'(c - "A" + 8'd10);
            hexd = 1'b1;
         end
         if (hexd) begin
            lex.hex_digit = 1'b1;
            if (lex.accum[WORD_BITS-1 -: 4] != '0) begin
               lex.overflow = 1'b1;
            end else if (!lex.overflow) begin
               lex.accum = (lex.accum << 4) + WORD_BITS'(d);
            end
            // a hex e lets a following sign join the pp-number
            lex.last_e = e_char(c);
            return 1'b0;
         end
         ph = PH_SUFFIX;
      end

      // one u and one l, either order; a repeat drops into the tail
      if (ph == PH_SUFFIX) begin
         if ((c == "u" || c == "U") && !lex.u_sfx) begin
            lex.u_sfx  = 1'b1;
            lex.last_e = 1'b0;
            lex.phase  = PH_SUFFIX;
            return 1'b0;
         end
         if ((c == "l" || c == "L") && !lex.l_sfx) begin
            lex.l_sfx  = 1'b1;
            lex.last_e = 1'b0;
            lex.phase  = PH_SUFFIX;
            return 1'b0;
         end
      end

      // tail: leftover pp-number characters, exponent sign included
      if (pp_char(c)) begin
         lex.tail   = 1'b1;
         lex.last_e = e_char(c);
         lex.phase  = PH_TAIL;
         return 1'b0;
      end
      if (sign_char(c) && lex.last_e) begin
         lex.tail   = 1'b1;
         lex.last_e = 1'b0;
         lex.phase  = PH_TAIL;
         return 1'b0;
      end

      // terminator: overflow reports the signed maximum
      v                   = lex.overflow ? SIGNED_MAX : lex.accum;
      tok.value           = v;
      tok.is_unsigned     = lex.u_sfx || (v > SIGNED_MAX);
      tok.overflowed      = lex.overflow;
      tok.bad_octal_digit = lex.octal_err;
      tok.empty_hex       = !lex.hex_digit;
      tok.bad_pp_number   = lex.tail;
      lex_clear();
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // compare one rsp beat with the oldest queued constant
   // ------------------------------------------------------------------
   function automatic void check_constant(input rsp_type want, input rsp_type got);
      if (got.value !== want.value) begin
         $error("value: expected %0h, got %0h", want.value, got.value);
         fail_count++;
      end
      if (got.is_unsigned !== want.is_unsigned) begin
         $error("is_unsigned: expected %0b, got %0b", want.is_unsigned, got.is_unsigned);
         fail_count++;
      end
      if (got.is_float !== want.is_float) begin
         $error("is_float: expected %0b, got %0b", want.is_float, got.is_float);
         fail_count++;
      end
      if (got.overflowed !== want.overflowed) begin
         $error("overflowed: expected %0b, got %0b", want.overflowed, got.overflowed);
         fail_count++;
      end
      if (got.bad_octal_digit !== want.bad_octal_digit) begin
         $error("bad_octal_digit: expected %0b, got %0b",
                want.bad_octal_digit, got.bad_octal_digit);
         fail_count++;
      end
      if (got.empty_hex !== want.empty_hex) begin
         $error("empty_hex: expected %0b, got %0b", want.empty_hex, got.empty_hex);
         fail_count++;
      end
      if (got.bad_pp_number !== want.bad_pp_number) begin
         $error("bad_pp_number: expected %0b, got %0b",
                want.bad_pp_number, got.bad_pp_number);
         fail_count++;
      end
   endfunction

   // monitor: everything sampled at the rising edge
   always @(posedge clock) begin
      rsp_type predicted;
      rsp_type got;
      if (reset) begin
         lex_clear();
      end else begin
         // req beat: step the predictor, queue any constant it closes
         if (req_if.valid && req_if.ready) begin
            scanned_chars++;
            if (lex_char(req_if.ch, predicted)) begin
               if (pinned_taken != pinned_count) begin
                  pending_constants.push_back(row_want);
                  pinned_taken++;
               end else begin
                  pending_constants.push_back(predicted);
               end
            end
         end
         // rsp beat: must match the oldest queued constant
         if (rsp_if.valid && rsp_if.ready) begin
            got.value           = rsp_if.value;
            got.is_unsigned     = rsp_if.is_unsigned;
            got.is_float        = rsp_if.is_float;
            got.overflowed      = rsp_if.overflowed;
            got.bad_octal_digit = rsp_if.bad_octal_digit;
            got.empty_hex       = rsp_if.empty_hex;
            got.bad_pp_number   = rsp_if.bad_pp_number;
            if (pending_constants.size() == 0) begin
               $error("unexpected rsp beat, value %0h", rsp_if.value);
               fail_count++;
            end else begin
               check_constant(pending_constants.pop_front(), got);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // rsp side: random stall per beat, plus the long hold-offs on request
   // ------------------------------------------------------------------
   initial begin : rsp_drain
      int stall;
      int holds_served;
      rsp_if.ready = 1'b0;
      holds_served = 0;
      wait (!reset);
      @(negedge clock);
      forever begin
         // long hold-off: the block backs up and drops req_ready
         if (hold_requests > holds_served) begin
            holds_served++;
            rsp_if.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
         end
         stall = quiet ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         @(negedge clock);
      end
   end

   // ------------------------------------------------------------------
   // req side: drive at the falling edge, hold until the beat lands
   // ------------------------------------------------------------------
   task automatic send_char(input logic [CHAR_BITS-1:0] c);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.ch    <= c;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   // one random token: mostly well-formed constants, some noise
   task automatic send_random_token();
      int   shape;
      int   n;
      int   sfx;
      logic [CHAR_BITS-1:0] c;
      string hex_set;
      string sfx_set;
      string tail_set;
      string lead_set;
      string float_set;
      string term_set;
      hex_set   = "0123456789abcdefABCDEF";
      sfx_set   = "uUlL";
      tail_set  = "eE+-_.zZ9aqxuL";
      lead_set  = ".eE";
      float_set = "0123456789eE+-.xa_";
      term_set  = " ,;)]\n";
      shape     = $urandom_range(0, 9);

      // raw bytes, any value
      if (shape == 9) begin
         repeat ($urandom_range(1, 5)) send_char(8'($urandom_range(0, 255)));
         return;
      end

      // short digit runs mostly, now and then long enough to overflow
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 4);
      if (shape <= 2 || shape == 7) begin
         send_char(8'("0" + $urandom_range(1, 9)));
         repeat (n) send_char(8'("0" + $urandom_range(0, 9)));
      end else if (shape <= 4 || shape == 8) begin
         send_char("0");
         repeat (n) begin
            if ($urandom_range(0, 15) == 0) send_char(8'("8" + $urandom_range(0, 1)));
            else send_char(8'("0" + $urandom_range(0, 7)));
         end
      end else begin
         send_char("0");
         send_char($urandom_range(0, 1) ? "x" : "X");
         repeat (n) send_char(hex_set[$urandom_range(0, hex_set.len() - 1)]);
      end

      if (shape >= 7) begin
         // float handoff and the pp-number that follows it
         send_char(lead_set[$urandom_range(0, lead_set.len() - 1)]);
         repeat ($urandom_range(0, 4))
            send_char(float_set[$urandom_range(0, float_set.len() - 1)]);
      end else begin
         sfx = $urandom_range(0, 5);
         if (sfx >= 3) begin
            repeat (sfx - 2) send_char(sfx_set[$urandom_range(0, 3)]);
         end
         if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 3))
               send_char(tail_set[$urandom_range(0, tail_set.len() - 1)]);
         end
      end

      // terminator: usual punctuation, end of input, or any non pp byte
      if ($urandom_range(0, 1)) begin
         c = term_set[$urandom_range(0, term_set.len() - 1)];
      end else if ($urandom_range(0, 3) == 0) begin
         c = END_OF_INPUT;
      end else begin
         do c = 8'($urandom_range(0, 255)); while (pp_char(c));
      end
      send_char(c);
   endtask

   // ------------------------------------------------------------------
   // main stimulus
   // ------------------------------------------------------------------
   initial begin : stimulus
      lex_row_type rows[$];
      int          base;
      int          tokens;
      int          quiet_left;

      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.ch    = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows; pinned ones carry the constant read off by hand
      rows = '{
         '{"0",            " ",          1, const_result(32'h0, 0, 0, 0, 0, 0, 0)},
         '{"4294967295",   " ",          1, const_result(32'hFFFFFFFF, 1, 0, 0, 0, 0, 0)},
         '{"4294967296",   ",",          1, const_result(SIGNED_MAX, 0, 0, 1, 0, 0, 0)},
         '{"2147483648",   ";",          1, const_result(32'h80000000, 1, 0, 0, 0, 0, 0)},
         '{"0xFFFFFFFF",   ")",          1, const_result(32'hFFFFFFFF, 1, 0, 0, 0, 0, 0)},
         '{"0X100000000",  " ",          1, const_result(SIGNED_MAX, 0, 0, 1, 0, 0, 0)},
         '{"037777777777", " ",          1, const_result(32'hFFFFFFFF, 1, 0, 0, 0, 0, 0)},
         '{"040000000000", " ",          1, const_result(SIGNED_MAX, 0, 0, 1, 0, 0, 0)},
         '{"0x",           " ",          1, const_result(32'h0, 0, 0, 0, 0, 1, 0)},
         '{"089",          " ",          1, const_result(32'd73, 0, 0, 0, 1, 0, 0)},
         '{"12.5",         " ",          1, const_result(32'h0, 0, 1, 0, 0, 0, 0)},
         '{"0e+5",         ";",          1, const_result(32'h0, 0, 1, 0, 0, 0, 0)},
         '{"0x1e+2",       " ",          1, const_result(32'h1E, 0, 0, 0, 0, 0, 1)},
         '{"7uL",          " ",          1, const_result(32'd7, 1, 0, 0, 0, 0, 0)},
         '{"7LU",          " ",          1, const_result(32'd7, 1, 0, 0, 0, 0, 0)},
         '{"7uu",          " ",          1, const_result(32'd7, 1, 0, 0, 0, 0, 1)},
         '{"7ll",          " ",          1, const_result(32'd7, 0, 0, 0, 0, 0, 1)},
         '{"12abc",        " ",          1, const_result(32'd12, 0, 0, 0, 0, 0, 1)},
         '{"5e-3x",        " ",          1, const_result(32'h0, 0, 1, 0, 0, 0, 0)},
         '{"42",           8'hFF,        1, const_result(32'd42, 0, 0, 0, 0, 0, 0)},
         '{"ab.+",         "#",          0, '0},
         '{"0x12345678",   END_OF_INPUT, 1, const_result(32'h12345678, 0, 0, 0, 0, 0, 0)},
         '{"077",          8'h80,        1, const_result(32'd63, 0, 0, 0, 0, 0, 0)},
         '{"1.+",          " ",          1, const_result(32'h0, 0, 1, 0, 0, 0, 0)},
         '{"09.9e-1",      " ",          1, const_result(32'h0, 0, 1, 0, 0, 0, 0)},
         '{"99999999999",  "]",          0, '0}
      };

      foreach (rows[i]) begin
         if (rows[i].pinned != 0) begin
            row_want = rows[i].want;
            pinned_count++;
         end
         for (int k = 0; k < rows[i].body.len(); k++) send_char(rows[i].body[k]);
         send_char(rows[i].term);
      end

      // random part: quiet stretches now and then, two long rsp holds
      base       = scanned_chars;
      tokens     = 0;
      quiet_left = 0;
      while (scanned_chars - base < RANDOM_CHARS) begin
         if (tokens == 60 || tokens == 180) begin
            // keep req beats coming back to back while rsp is held off
            hold_requests++;
            quiet_left = 40;
         end else if (quiet_left > 0) begin
            quiet_left--;
         end else if ($urandom_range(0, 15) == 0) begin
            quiet_left = $urandom_range(3, 12);
         end
         quiet = (quiet_left > 0);
         send_random_token();
         tokens++;
      end
      quiet = 1'b0;

      // end of input closes whatever is still open
      send_char(END_OF_INPUT);
      req_if.valid <= 1'b0;

      while (pending_constants.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
